@@ design/i2cm_pkg.sv @@
// Shared types and constants for the I2C master engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  localparam int unsigned HP_W     = 16;
  localparam logic [HP_W-1:0] HP_RESET = 16'd5;

  // Opcodes on the command channel
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Transaction status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_PUSH,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] addr;
    logic [4:0] wcount;
    logic [7:0] rcount;
    logic [7:0] wbyte;
    logic       sda;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       rvalid;
    logic [7:0] rdata;
    logic       rlast;
    logic       done;
    logic [1:0] status;
  } res_t;

  // Write buffer control and status
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic [7:0] data;
  } wbuf_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head;
  } wbuf_stat_t;

endpackage
`default_nettype wire

@@ design/i2cm_ifs.sv @@
// Channel interfaces: command input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [6:0] target_address;
  logic [4:0] write_count;
  logic [7:0] read_count;
  logic [7:0] write_byte;
  logic       sda_in;

  modport source (output valid, opcode, target_address, write_count, read_count,
                  write_byte, sda_in, input ready);
  modport sink (input valid, opcode, target_address, write_count, read_count,
                write_byte, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_out, sda_out, busy_res, read_valid, read_data,
                  read_last, done_res, status, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, read_valid, read_data,
                read_last, done_res, status, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ design/i2cm_front.sv @@
// Front end: decodes incoming transactions and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [6:0] in_addr,
  input  wire logic [4:0] in_wcount,
  input  wire logic [7:0] in_rcount,
  input  wire logic [7:0] in_wbyte,
  input  wire logic       in_sda,
  output logic            q_valid,
  input  wire logic       q_ready,
  output cmd_t            q_cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.addr   = in_addr;
    dec.wcount = in_wcount;
    dec.rcount = in_rcount;
    dec.wbyte  = in_wbyte;
    dec.sda    = in_sda;
    unique case (in_opcode)
      OP_BEGIN: dec.kind = CMD_BEGIN;
      OP_PUSH:  dec.kind = CMD_PUSH;
      OP_TICK:  dec.kind = CMD_TICK;
      default:  dec.kind = CMD_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

@@ design/i2cm_wbuf.sv @@
// Write data buffer: circular memory with a prefetched head byte.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_wbuf
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wbuf_ctl_t ctl,
  output wbuf_stat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (ctl.flush) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      fill_nxt   = '0;
    end else if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end else if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // head byte is read ahead at the next read pointer; bypass a push into it
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.flush) begin
      mem[wr_ptr_r] <= ctl.data;
    end
    if (ctl.push && !ctl.flush && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= ctl.data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(DEPTH));
  assign stat.head  = head_r;

endmodule
`default_nettype wire

@@ design/i2cm_engine.sv @@
// Back end: bus phase sequencer, bit shifter and registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  cmd_t                  q_cmd,
  input  wire logic             cfg_wr,
  input  wire logic [HP_W-1:0]  cfg_data,
  output wbuf_ctl_t             wctl,
  input  wbuf_stat_t            wstat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output res_t                  out_res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
    PH_WB_SET, PH_WB_HIGH, PH_WB_LOW,
    PH_WA_REL, PH_WA_HIGH, PH_WA_LOW,
    PH_RB_LOW, PH_RB_HIGH,
    PH_RA_SET, PH_RA_HIGH, PH_RA_LOW,
    PH_SP0, PH_SP1, PH_SP2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WADDR,
    KIND_RADDR,
    KIND_DATA
  } kind_t;

  phase_t          phase_r, phase_nxt, enter_ph;
  kind_t           kind_r, kind_nxt;
  logic [HP_W-1:0] hp_r;
  logic [HP_W-1:0] tick_r, tick_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [4:0]      wleft_r, wleft_nxt;
  logic [7:0]      rleft_r, rleft_nxt, rleft_dec;
  logic [6:0]      addr_r, addr_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            out_valid_r;
  res_t            res_r, res_nxt;
  logic            take;
  logic            enter_en;
  logic [HP_W-1:0] half;
  logic [HP_W:0]   tick_sum;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_ready   = !out_valid_r || out_ready;
  assign half      = (hp_r == '0) ? HP_W'(1) : hp_r;
  assign tick_sum  = {1'b0, tick_r} + 1'b1;
  assign rleft_dec = (rleft_r != 8'd0) ? rleft_r - 8'd1 : 8'd0;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    wleft_nxt  = wleft_r;
    rleft_nxt  = rleft_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    enter_en   = 1'b0;
    enter_ph   = PH_IDLE;
    wctl       = '0;
    wctl.data  = q_cmd.wbyte;
    res_nxt    = '0;

    case (q_cmd.kind)
      CMD_BEGIN: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt   = q_cmd.addr;
          wleft_nxt  = q_cmd.wcount;
          rleft_nxt  = q_cmd.rcount;
          status_nxt = ST_OK;
          kind_nxt   = (q_cmd.wcount == 5'd0 && q_cmd.rcount != 8'd0) ? KIND_RADDR
                                                                      : KIND_WADDR;
          enter_en   = 1'b1;
          enter_ph   = PH_ST0;
        end
      end
      CMD_PUSH: begin
        wctl.push = !wstat.full;
      end
      CMD_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_nxt = tick_sum[HP_W-1:0];
          if (tick_sum >= {1'b0, half}) begin
            enter_en = 1'b1;
            unique case (phase_r)
              PH_ST0:     enter_ph = PH_ST1;
              PH_ST1:     enter_ph = PH_ST2;
              PH_ST2:     enter_ph = PH_ST3;
              PH_ST3: begin
                shift_nxt = {addr_r, kind_r == KIND_RADDR};
                bit_nxt   = 3'd7;
                enter_ph  = PH_WB_SET;
              end
              PH_WB_SET:  enter_ph = PH_WB_HIGH;
              PH_WB_HIGH: enter_ph = PH_WB_LOW;
              PH_WB_LOW: begin
                if (bit_r == 3'd0) begin
                  enter_ph = PH_WA_REL;
                end else begin
                  bit_nxt  = bit_r - 3'd1;
                  enter_ph = PH_WB_SET;
                end
              end
              PH_WA_REL:  enter_ph = PH_WA_HIGH;
              PH_WA_HIGH: begin
                // keep the ACK level: zero means acknowledged
                shift_nxt = {7'd0, q_cmd.sda};
                enter_ph  = PH_WA_LOW;
              end
              PH_WA_LOW: begin
                if (shift_r != 8'd0) begin
                  status_nxt = (kind_r == KIND_DATA) ? ST_DATA_NACK : ST_ADDR_NACK;
                  enter_ph   = PH_SP0;
                end else if (kind_r == KIND_RADDR) begin
                  bit_nxt   = 3'd7;
                  shift_nxt = 8'd0;
                  enter_ph  = PH_RB_LOW;
                end else if (wleft_r != 5'd0) begin
                  wleft_nxt = wleft_r - 5'd1;
                  kind_nxt  = KIND_DATA;
                  shift_nxt = wstat.empty ? 8'd0 : wstat.head;
                  wctl.pop  = !wstat.empty;
                  bit_nxt   = 3'd7;
                  enter_ph  = PH_WB_SET;
                end else if (rleft_r != 8'd0) begin
                  kind_nxt = KIND_RADDR;
                  enter_ph = PH_ST0;
                end else begin
                  status_nxt = ST_OK;
                  enter_ph   = PH_SP0;
                end
              end
              PH_RB_LOW:  enter_ph = PH_RB_HIGH;
              PH_RB_HIGH: begin
                if (q_cmd.sda) begin
                  shift_nxt[bit_r] = 1'b1;
                end
                if (bit_r == 3'd0) begin
                  enter_ph = PH_RA_SET;
                end else begin
                  bit_nxt  = bit_r - 3'd1;
                  enter_ph = PH_RB_LOW;
                end
              end
              PH_RA_SET:  enter_ph = PH_RA_HIGH;
              PH_RA_HIGH: enter_ph = PH_RA_LOW;
              PH_RA_LOW: begin
                res_nxt.rvalid = 1'b1;
                res_nxt.rdata  = shift_r;
                res_nxt.rlast  = (rleft_r <= 8'd1);
                rleft_nxt      = rleft_dec;
                if (rleft_dec != 8'd0) begin
                  bit_nxt   = 3'd7;
                  shift_nxt = 8'd0;
                  enter_ph  = PH_RB_LOW;
                end else begin
                  status_nxt = ST_OK;
                  enter_ph   = PH_SP0;
                end
              end
              PH_SP0:     enter_ph = PH_SP1;
              PH_SP1:     enter_ph = PH_SP2;
              PH_SP2: begin
                res_nxt.done = 1'b1;
                wctl.flush   = 1'b1;
                enter_ph     = PH_IDLE;
              end
              default:    enter_ph = PH_IDLE;
            endcase
          end
        end
      end
      default: ;
    endcase

    // line levels change on phase entry
    if (enter_en) begin
      phase_nxt = enter_ph;
      tick_nxt  = '0;
      unique case (enter_ph)
        PH_ST0:     sda_nxt = 1'b1;
        PH_ST1:     scl_nxt = 1'b1;
        PH_ST2:     sda_nxt = 1'b0;
        PH_ST3:     scl_nxt = 1'b0;
        PH_WB_SET:  sda_nxt = shift_nxt[bit_nxt];
        PH_WB_HIGH: scl_nxt = 1'b1;
        PH_WB_LOW:  scl_nxt = 1'b0;
        PH_WA_REL:  sda_nxt = 1'b1;
        PH_WA_HIGH: scl_nxt = 1'b1;
        PH_WA_LOW:  scl_nxt = 1'b0;
        PH_RB_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        PH_RB_HIGH: scl_nxt = 1'b1;
        PH_RA_SET: begin
          scl_nxt = 1'b0;
          sda_nxt = (rleft_nxt > 8'd1) ? 1'b0 : 1'b1;
        end
        PH_RA_HIGH: scl_nxt = 1'b1;
        PH_RA_LOW:  scl_nxt = 1'b0;
        PH_SP0:     sda_nxt = 1'b0;
        PH_SP1:     scl_nxt = 1'b1;
        PH_SP2:     sda_nxt = 1'b1;
        default: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
      endcase
    end

    res_nxt.scl    = scl_nxt;
    res_nxt.sda    = sda_nxt;
    res_nxt.busy   = (phase_nxt != PH_IDLE);
    res_nxt.status = status_nxt;

    if (!take) begin
      wctl.push  = 1'b0;
      wctl.pop   = 1'b0;
      wctl.flush = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      kind_r      <= KIND_WADDR;
      hp_r        <= HP_RESET;
      tick_r      <= '0;
      bit_r       <= 3'd7;
      shift_r     <= 8'd0;
      wleft_r     <= 5'd0;
      rleft_r     <= 8'd0;
      addr_r      <= 7'd0;
      status_r    <= ST_OK;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        hp_r <= cfg_data;
      end
      if (take) begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        tick_r   <= tick_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        wleft_r  <= wleft_nxt;
        rleft_r  <= rleft_nxt;
        addr_r   <= addr_nxt;
        status_r <= status_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

@@ design/i2c_master_write_read.sv @@
// I2C master engine top level: front end, write buffer and phase engine.
//
// Channels: in_if carries one command per transaction: begin (address, write and
// read counts), queue a write byte, or a time tick with the sampled SDA level.
// Every accepted command yields exactly one result on out_if: SCL/SDA levels,
// busy, an optional received byte (read_valid/read_data/read_last), done and the
// status of the last bus transfer. cfg_if writes half_period_ticks (always ready)
// and must only be used while the engine is idle.
// An accepted command is held in the command queue and its result is registered.
// Throughput: one command per cycle while out_if.ready stays high; every command is
// a single state update of the phase engine, and the two-entry command queue plus
// the result register let both sides stall independently.
// Reset (rst_n low, synchronous) empties the queue and the write buffer, drops
// any pending result, releases both lines and restores half_period_ticks to 5.
// When out_if.ready is low the result is held; the queue keeps taking commands
// until its two entries are full, then in_if.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_write_read
  import i2cm_pkg::*;
#(
  parameter int unsigned WRITE_DEPTH = 16
)(
  input  wire logic  clk,
  input  wire logic  rst_n,
  i2cm_in_if.sink    in_if,
  i2cm_out_if.source out_if,
  i2cm_cfg_if.sink   cfg_if
);

  logic       q_valid;
  logic       q_ready;
  cmd_t       q_cmd;
  wbuf_ctl_t  wctl;
  wbuf_stat_t wstat;
  res_t       res;

  assign cfg_if.ready = 1'b1;

  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_opcode (in_if.opcode),
    .in_addr   (in_if.target_address),
    .in_wcount (in_if.write_count),
    .in_rcount (in_if.read_count),
    .in_wbyte  (in_if.write_byte),
    .in_sda    (in_if.sda_in),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  i2cm_wbuf #(
    .DEPTH (WRITE_DEPTH)
  ) u_wbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (wctl),
    .stat  (wstat)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .cfg_wr    (cfg_if.valid),
    .cfg_data  (cfg_if.data),
    .wctl      (wctl),
    .wstat     (wstat),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  assign out_if.scl_out    = res.scl;
  assign out_if.sda_out    = res.sda;
  assign out_if.busy_res   = res.busy;
  assign out_if.read_valid = res.rvalid;
  assign out_if.read_data  = res.rdata;
  assign out_if.read_last  = res.rlast;
  assign out_if.done_res   = res.done;
  assign out_if.status     = res.status;

endmodule
`default_nettype wire

@@ design/i2cm_checker.sv @@
// Port-level checks on the I2C master result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_checker
  import i2cm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       busy_res,
  input wire logic       read_valid,
  input wire logic [7:0] read_data,
  input wire logic       read_last,
  input wire logic       done_res,
  input wire logic [1:0] status
);

  // a stalled result stays presented
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res && !read_valid)
    else $error("done reported while still busy");

  a_rd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_valid |-> read_data == 8'd0 && !read_last)
    else $error("read fields set without a received byte");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_OK || status == ST_ADDR_NACK || status == ST_DATA_NACK)
    else $error("bad status code");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

endmodule

bind i2c_master_write_read i2cm_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .busy_res   (out_if.busy_res),
  .read_valid (out_if.read_valid),
  .read_data  (out_if.read_data),
  .read_last  (out_if.read_last),
  .done_res   (out_if.done_res),
  .status     (out_if.status)
);
`default_nettype wire
